### rtl/core/url_percent_decoder_assert.svh
// Assertion macros shared by the URL percent decoder RTL.
// Included by bare file name; needs nothing else.
`ifndef URL_PERCENT_DECODER_ASSERT_SVH
`define URL_PERCENT_DECODER_ASSERT_SVH

// Clocked property, switched off while the reset is asserted.
`define UPD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Clocked property that is also checked while the reset is asserted.
`define UPD_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`endif

### rtl/core/upd_pkg.sv
// Shared types, character constants and the hex mapping of the URL percent decoder.
// No dependencies.
package upd_pkg;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;

  // One encoded word as it travels from the input register to the decoder.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } upd_item_t;

  // One decoded word as it travels from the decoder to the result register.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } upd_result_t;

  // Unchecked hex mapping: digits lose 48, everything else is lowercased and loses 87.
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = c;
    if (c inside {[8'h30:8'h39]}) begin
      return c - 8'd48;
    end
    if (c inside {[8'h41:8'h5A]}) begin
      v = c + 8'h20;
    end
    return v - 8'd87;
  endfunction

endpackage

### rtl/core/url_percent_decoder.sv
// URL percent decoder: top level, turns an encoded byte stream into decoded bytes.
// Depends on upd_pkg, upd_in_stage, upd_decode, upd_out_stage and
// url_percent_decoder_assert.svh.
//
// The input channel (in_valid_i, in_ready_o) carries one encoded word per
// handshake: a raw byte and a flag that marks the final byte of a string.
// The output channel (out_valid_o, out_ready_i) carries decoded words: a byte,
// a flag that says whether the byte is meaningful, and the end-of-string mark.
// A plus sign becomes a space, and a percent sign followed by two bytes
// becomes one byte through an unchecked hex mapping. A word that completes no
// character (a percent sign, or the first byte of an escape) produces no output
// word. A final percent sign sends a word carrying only the end mark, and a final
// byte right after a percent sign is decoded as a plain byte.
// An accepted word enters the input register and is decoded from there into the
// result register, which the receiver reads. The block takes one word every cycle
// while the receiver keeps up; the escape state is a three-state machine, so
// nothing else limits the rate below one word per clock.
// When the receiver stalls, the result register holds its word and the input
// register fills; in_ready_o then falls until the receiver takes the word.
// An asynchronous reset empties both registers and puts the escape state
// machine back into its normal phase.
`include "url_percent_decoder_assert.svh"

module url_percent_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       out_last_o
);

  upd_pkg::upd_item_t   in_item;
  upd_pkg::upd_item_t   held_item;
  upd_pkg::upd_result_t dec_result;
  upd_pkg::upd_result_t out_result;
  logic                 held_valid;
  logic                 out_room;
  logic                 fire;
  logic                 dec_push;

  assign in_item.data = in_byte_i;
  assign in_item.last = in_last_i;

  // A held word is decoded once the result register can take whatever it yields.
  assign fire = held_valid && out_room;

  upd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item),
    .valid_o (held_valid),
    .pop_i   (fire),
    .item_o  (held_item)
  );

  upd_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (held_item),
    .emit_o   (dec_push),
    .result_o (dec_result)
  );

  upd_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (dec_push),
    .result_i (dec_result),
    .room_o   (out_room),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (out_result)
  );

  assign out_byte_o = out_result.data;
  assign has_byte_o = out_result.has_byte;
  assign out_last_o = out_result.last;

  `UPD_ASSERT(a_push_has_room, clk_i, rst_ni,
    dec_push |-> out_room, "decoded word pushed into a full result register")
  `UPD_ASSERT_ALWAYS(a_reset_empties, clk_i,
    !rst_ni |-> !out_valid_o && !held_valid, "registers hold a word during reset")

endmodule

### rtl/core/upd_in_stage.sv
// Input register of the URL percent decoder: holds one encoded word.
// Depends on upd_pkg.
module upd_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  upd_pkg::upd_item_t item_i,
  output logic              valid_o,
  input  logic              pop_i,
  output upd_pkg::upd_item_t item_o
);

  logic               valid_q, valid_d;
  upd_pkg::upd_item_t item_q;
  logic               load;

  assign ready_o = !valid_q || pop_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load || (valid_q && !pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### rtl/core/upd_decode.sv
// Escape state machine and decode logic of the URL percent decoder.
// Depends on upd_pkg and url_percent_decoder_assert.svh.
`include "url_percent_decoder_assert.svh"

module upd_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  upd_pkg::upd_item_t  item_i,
  output logic                emit_o,
  output upd_pkg::upd_result_t result_o
);

  typedef enum logic [2:0] {
    PH_NORMAL = 3'b001,
    PH_PCT    = 3'b010,
    PH_HELD   = 3'b100
  } upd_phase_e;

  upd_phase_e  phase_q, phase_d;
  logic [7:0]  first_q, first_d;
  logic        plain;
  logic        have;
  logic [7:0]  val;
  logic [7:0]  hi, lo;

  assign hi = upd_pkg::hex_value(first_q);
  assign lo = upd_pkg::hex_value(item_i.data);

  always_comb begin
    phase_d = PH_NORMAL;
    first_d = first_q;
    plain   = 1'b0;
    have    = 1'b0;
    val     = 8'h00;
    case (phase_q)
      PH_HELD: begin
        val  = {hi[3:0], 4'h0} | lo;
        have = 1'b1;
      end
      PH_PCT: begin
        if (!item_i.last) begin
          first_d = item_i.data;
          phase_d = PH_HELD;
        end else begin
          plain = 1'b1;
        end
      end
      default: begin
        plain = 1'b1;
      end
    endcase
    if (plain) begin
      if (item_i.data == upd_pkg::ChPercent) begin
        if (!item_i.last) begin
          phase_d = PH_PCT;
        end
      end else if (item_i.data == upd_pkg::ChPlus) begin
        val  = upd_pkg::ChSpace;
        have = 1'b1;
      end else begin
        val  = item_i.data;
        have = 1'b1;
      end
    end
    if (item_i.last) begin
      phase_d = PH_NORMAL;
      first_d = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NORMAL;
    end else if (fire_i) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      first_q <= first_d;
    end
  end

  assign emit_o            = fire_i && (have || item_i.last);
  assign result_o.data     = val;
  assign result_o.has_byte = have;
  assign result_o.last     = item_i.last;

  `UPD_ASSERT(a_last_clears_phase, clk_i, rst_ni,
    fire_i && item_i.last |=> phase_q == PH_NORMAL, "escape state survives end of string")
  `UPD_ASSERT(a_pct_then_held, clk_i, rst_ni,
    fire_i && phase_q == PH_PCT && !item_i.last |=> phase_q == PH_HELD,
    "first escape character not held")
  `UPD_ASSERT(a_empty_result_is_end, clk_i, rst_ni,
    emit_o && !result_o.has_byte |-> result_o.last && result_o.data == 8'h00,
    "empty result without end mark")

endmodule

### rtl/core/upd_out_stage.sv
// Result register of the URL percent decoder: holds one decoded word for the receiver.
// Depends on upd_pkg.
module upd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  upd_pkg::upd_result_t result_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                ready_i,
  output upd_pkg::upd_result_t result_o
);

  logic                 valid_q, valid_d;
  upd_pkg::upd_result_t result_q;

  assign room_o  = !valid_q || ready_i;
  assign valid_d = push_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

### tb/sv/url_percent_decoder_tb.sv
// Self-checking testbench for url_percent_decoder: a stimulus queue feeds a clocked
// driver, a clocked monitor checks every decoded word against a built-in decoder.
// Depends on upd_pkg and the url_percent_decoder RTL.
module url_percent_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumWords       = 1950;
  localparam int unsigned RxHoldCycles   = 80;
  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned TailCycles     = 8;

  // Escape phases of the decoder as the testbench tracks them.
  typedef enum logic [1:0] {
    PH_NORMAL    = 2'd0,
    PH_PERCENT   = 2'd1,
    PH_FIRST_HEX = 2'd2
  } esc_phase_e;

  // One encoded word waiting to be sent, with the idle cycles in front of it and
  // a flag that makes the sender wait until every decoded word has arrived.
  typedef struct {
    logic [7:0]  data;
    logic        last;
    int unsigned gap;
    bit          drain;
  } enc_word_t;

  typedef struct {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } dec_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       in_last_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       has_byte_o;
  logic       out_last_o;

  enc_word_t   enc_q[$];
  dec_word_t   decoded_q[$];
  enc_word_t   enc_next;
  dec_word_t   dec_want;
  esc_phase_e  esc_phase = PH_NORMAL;
  logic [7:0]  esc_first = 8'h00;
  int unsigned tx_mode = 0;
  int unsigned rx_mode = 0;
  int unsigned tx_gap_cnt;
  int unsigned rx_wait;
  int unsigned words_sent = 0;
  int unsigned words_seen = 0;
  int unsigned fail_cnt = 0;
  int unsigned quiet_cycles = 0;
  logic        rx_hold = 1'b0;

  url_percent_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .has_byte_o  (has_byte_o),
    .out_last_o  (out_last_o)
  );

  always #1 clk_i = ~clk_i;

  // Idle cycles for one word. Mode 0 never idles, mode 1 idles freely and mode 2
  // idles now and then, so that both busy stretches and sparse traffic occur.
  function automatic int unsigned draw_wait(input int unsigned mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 11);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
    endcase
  endfunction

  // Unchecked hex value of one character: digits map to 0..9, and any other
  // character is folded to lower case and offset so that 'a' gives ten.
  function automatic logic [7:0] hex_nibble(input logic [7:0] c);
    logic [7:0] folded;
    if (c >= 8'h30 && c <= 8'h39) begin
      return c - 8'h30;
    end
    folded = (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
    return folded - 8'd87;
  endfunction

  // Runs one accepted word through the decoder state and queues the decoded word
  // that it produces, if any.
  task automatic decode_word(input logic [7:0] b, input logic fin);
    dec_word_t  r;
    logic [7:0] hi;
    logic [7:0] lo;
    r.data     = 8'h00;
    r.has_byte = 1'b0;
    r.last     = fin;
    if (esc_phase == PH_FIRST_HEX) begin
      hi         = hex_nibble(esc_first);
      lo         = hex_nibble(b);
      r.data     = (hi << 4) | lo;
      r.has_byte = 1'b1;
      esc_phase  = PH_NORMAL;
    end else if (esc_phase == PH_PERCENT && !fin) begin
      esc_first = b;
      esc_phase = PH_FIRST_HEX;
    end else begin
      // A normal byte, or the lone byte left over when the string ends one
      // byte after a percent sign.
      esc_phase = PH_NORMAL;
      if (b == upd_pkg::ChPercent) begin
        if (!fin) begin
          esc_phase = PH_PERCENT;
        end
      end else if (b == upd_pkg::ChPlus) begin
        r.data     = upd_pkg::ChSpace;
        r.has_byte = 1'b1;
      end else begin
        r.data     = b;
        r.has_byte = 1'b1;
      end
    end
    if (fin) begin
      esc_phase = PH_NORMAL;
      esc_first = 8'h00;
    end
    if (r.has_byte || fin) begin
      decoded_q.push_back(r);
    end
  endtask

  task automatic push_word(input logic [7:0] b, input logic fin);
    enc_word_t w;
    if (enc_q.size() % 64 == 0) begin
      tx_mode = $urandom_range(0, 2);
    end
    w.data  = b;
    w.last  = fin;
    w.gap   = draw_wait(tx_mode);
    w.drain = (enc_q.size() == 600) || ($urandom_range(0, 149) == 0);
    enc_q.push_back(w);
  endtask

  // Mostly a proper hex digit in either case, sometimes any byte at all.
  function automatic logic [7:0] esc_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'h30 + 8'($urandom_range(0, 9));
      3, 4:    return 8'h41 + 8'($urandom_range(0, 5));
      5, 6:    return 8'h61 + 8'($urandom_range(0, 5));
      7:       return ($urandom_range(0, 1) == 1) ? upd_pkg::ChPlus : upd_pkg::ChPercent;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // A string of escapes, plus signs and printable characters, ended
  // now and then by an escape that is cut short.
  task automatic gen_string();
    logic [7:0]  s[$];
    int unsigned len;
    int unsigned k;
    len = $urandom_range(1, 10);
    for (k = 0; k < len; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          s.push_back(upd_pkg::ChPercent);
          s.push_back(esc_char());
          s.push_back(esc_char());
        end
        4: s.push_back(upd_pkg::ChPlus);
        default: s.push_back(8'($urandom_range(8'h21, 8'h7E)));
      endcase
    end
    case ($urandom_range(0, 5))
      0: s.push_back(upd_pkg::ChPercent);
      1: begin
        s.push_back(upd_pkg::ChPercent);
        s.push_back(esc_char());
      end
      default: ;
    endcase
    for (k = 0; k < s.size(); k++) begin
      push_word(s[k], k == s.size() - 1);
    end
  endtask

  // Raw bytes with the end mark scattered at random.
  task automatic gen_noise();
    int unsigned n;
    int unsigned k;
    logic [7:0]  b;
    n = $urandom_range(1, 12);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 5))
        0: b = upd_pkg::ChPercent;
        1: b = upd_pkg::ChPlus;
        default: b = 8'($urandom_range(0, 255));
      endcase
      push_word(b, $urandom_range(0, 7) == 0);
    end
  endtask

  // Sender: presents the head of the stimulus queue once its idle cycles have
  // passed, and holds valid and payload steady until the word is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_byte_i  <= 8'h00;
      in_last_i  <= 1'b0;
      tx_gap_cnt = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        decode_word(in_byte_i, in_last_i);
        words_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (enc_q.size() != 0 && tx_gap_cnt < enc_q[0].gap) begin
          tx_gap_cnt++;
          in_valid_i <= 1'b0;
        end else if (enc_q.size() != 0 && !(enc_q[0].drain && decoded_q.size() != 0)) begin
          enc_next = enc_q.pop_front();
          in_byte_i  <= enc_next.data;
          in_last_i  <= enc_next.last;
          in_valid_i <= 1'b1;
          tx_gap_cnt = 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each decoded word against the oldest expectation and then
  // stalls for a drawn number of cycles. The receiver mode changes every
  // hundred words so that stalls land on every phase of the escape handling.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected word: out_byte %02h has_byte %0b out_last %0b",
                 out_byte_o, has_byte_o, out_last_o);
          fail_cnt++;
        end else begin
          dec_want = decoded_q.pop_front();
          if (out_byte_o !== dec_want.data) begin
            $error("out_byte: expected %02h, got %02h", dec_want.data, out_byte_o);
            fail_cnt++;
          end
          if (has_byte_o !== dec_want.has_byte) begin
            $error("has_byte: expected %0b, got %0b", dec_want.has_byte, has_byte_o);
            fail_cnt++;
          end
          if (out_last_o !== dec_want.last) begin
            $error("out_last: expected %0b, got %0b", dec_want.last, out_last_o);
            fail_cnt++;
          end
        end
        words_seen++;
        if (words_seen % 100 == 0) begin
          rx_mode = $urandom_range(0, 2);
        end
        rx_wait = draw_wait(rx_mode);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_ready_i <= (rx_wait == 0) && !rx_hold;
    end
  end

  // One long back-pressure stretch while the sender keeps offering words, so
  // that both pipeline registers fill and in_ready_o has to fall.
  initial begin
    wait (words_sent >= 400);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (RxHoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Watchdog: ends the run if nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    // The reset falls once every process waits on its edge, so the
    // asynchronous reset takes effect before the first clock edge.
    rst_ni <= 1'b0;
    // Directed strings: extreme bytes, plus sign, escapes with hex and non-hex
    // characters, a percent sign as the final byte, and strings that end one
    // byte after a percent sign (with a plus, a percent and a plain byte).
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(upd_pkg::ChPlus, 1'b0);
    push_word(upd_pkg::ChPercent, 1'b0);
    push_word(8'h34, 1'b0);
    push_word(8'h31, 1'b0);
    push_word(upd_pkg::ChPercent, 1'b0);
    push_word(8'h47, 1'b0);
    push_word(8'h7A, 1'b0);
    push_word(upd_pkg::ChPercent, 1'b1);
    push_word(upd_pkg::ChPercent, 1'b0);
    push_word(upd_pkg::ChPlus, 1'b1);
    push_word(upd_pkg::ChPercent, 1'b0);
    push_word(upd_pkg::ChPercent, 1'b1);
    push_word(upd_pkg::ChPercent, 1'b0);
    push_word(8'h51, 1'b1);
    push_word(upd_pkg::ChPercent, 1'b0);
    push_word(8'h30, 1'b0);
    push_word(8'h39, 1'b1);
    push_word(upd_pkg::ChPercent, 1'b0);
    push_word(8'h46, 1'b0);
    push_word(8'h66, 1'b0);
    push_word(8'h41, 1'b1);
    while (enc_q.size() < NumWords) begin
      if ($urandom_range(0, 3) != 0) begin
        gen_string();
      end else begin
        gen_noise();
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (enc_q.size() != 0 || in_valid_i || decoded_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/upd_pkg.sv
rtl/core/upd_in_stage.sv
rtl/core/upd_decode.sv
rtl/core/upd_out_stage.sv
rtl/core/url_percent_decoder.sv
tb/sv/url_percent_decoder_tb.sv
